FILE: hw/rtl/llcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llcc_pkg
// Shared types and constants for the laser line column centroid unit.
// ----------------------------------------------------------------------------
package llcc_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int PIXEL_BITS  = 16;
  localparam int COL_BITS    = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS    = $clog2(MAX_ROWS);
  localparam int DIM_BITS    = 11;
  localparam int LEN_BITS    = ROW_BITS + 1;
  localparam int SUM_BITS    = PIXEL_BITS + ROW_BITS;
  localparam int WSUM_BITS   = PIXEL_BITS + 2 * ROW_BITS;
  localparam int FRAC_BITS   = 8;
  localparam int CEN_BITS    = ROW_BITS + FRAC_BITS;

  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  typedef struct packed {
    logic                 run_open;
    logic [ROW_BITS-1:0]  run_start;
    logic [SUM_BITS-1:0]  run_sum;
    logic [WSUM_BITS-1:0] run_wsum;
    logic                 best_found;
    logic [ROW_BITS-1:0]  best_first;
    logic [ROW_BITS-1:0]  best_last;
    logic [LEN_BITS-1:0]  best_len;
    logic [SUM_BITS-1:0]  best_sum;
    logic [WSUM_BITS-1:0] best_wsum;
  } col_state_t;

endpackage

FILE: hw/rtl/llcc_col_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llcc_col_mem
// Per-column state memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module llcc_col_mem
  import llcc_pkg::*;
(
  input  logic                clk,
  input  logic                we,
  input  logic [COL_BITS-1:0] waddr,
  input  col_state_t          wdata,
  input  logic [COL_BITS-1:0] raddr,
  output col_state_t          rdata
);

  col_state_t mem [MAX_COLUMNS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/llcc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llcc_div
// Restoring divider, one quotient bit per cycle: (wsum << 8) / sum.
// ----------------------------------------------------------------------------
module llcc_div
  import llcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WSUM_BITS-1:0] dividend,
  input  logic [SUM_BITS-1:0]  divisor,
  output logic                 done,
  output logic [CEN_BITS-1:0]  quotient
);

  localparam int LOW_BITS = WSUM_BITS + FRAC_BITS - SUM_BITS;

  logic                busy;
  logic [4:0]          count;
  logic [SUM_BITS-1:0] rem;
  logic [LOW_BITS-1:0] low;
  logic [SUM_BITS-1:0] dvs;
  logic [SUM_BITS:0]   trial;

  // quotient < 2^CEN_BITS, so the top part of the dividend is already below divisor
  assign trial = {rem, low[LOW_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= 5'(CEN_BITS);
        rem      <= dividend[WSUM_BITS-1 -: SUM_BITS];
        low      <= {dividend[LOW_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        dvs      <= divisor;
        quotient <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem      <= SUM_BITS'(trial - {1'b0, dvs});
          quotient <= {quotient[CEN_BITS-2:0], 1'b1};
        end else begin
          rem      <= trial[SUM_BITS-1:0];
          quotient <= {quotient[CEN_BITS-2:0], 1'b0};
        end
        low   <= {low[LOW_BITS-2:0], 1'b0};
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/laser_line_column_centroid_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_line_column_centroid_unit
// Per-column brightest-run search over a pixel stream with row centroid output.
// ----------------------------------------------------------------------------
// Each pixel passes through read, update, multiply and write-back states,
// and the input accepts no new pixel until it is done. Last-row pixels
// add an output state, preceded by the bit-serial centroid divider when
// a spot was found. The result beat is then registered for output, and
// the output register frees the input side while it waits.
// Reset (rst, synchronous) clears counters, handshakes and config to defaults.
module laser_line_column_centroid_unit
  import llcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] pixel_value
  input  logic        s_axis_tuser,  // start_of_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [9:0] column_index, [10] spot_found, [20:11] run_first_row,
  // [30:21] run_last_row, [48:31] centroid_row, [55:49] zero
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,  // last_column
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_PUT  = 3'd6;

  logic [2:0]            state;
  logic [DIM_BITS-1:0]   frame_width;
  logic [DIM_BITS-1:0]   frame_height;
  logic [PIXEL_BITS-1:0] bright_threshold;
  logic [ROW_BITS-1:0]   row_counter;
  logic [COL_BITS-1:0]   column_counter;

  logic [DIM_BITS-1:0]   width_sat;
  logic [DIM_BITS-1:0]   height_sat;
  logic [ROW_BITS-1:0]   r_in;
  logic [COL_BITS-1:0]   c_in;
  logic                  last_row_in;
  logic                  last_col_in;
  logic                  accept;

  logic [ROW_BITS-1:0]   r_cur;
  logic [COL_BITS-1:0]   c_cur;
  logic [PIXEL_BITS-1:0] pix;
  logic                  bright;
  logic                  last_row;
  logic                  last_col;

  col_state_t            rdata;
  col_state_t            base;
  col_state_t            upd;
  col_state_t            work;
  col_state_t            wword;
  logic                  close;
  logic [ROW_BITS-1:0]   clast;
  logic [LEN_BITS-1:0]   clen;
  logic [SUM_BITS+LEN_BITS-1:0] prod_run;
  logic [SUM_BITS+LEN_BITS-1:0] prod_best;
  logic                  take;
  logic                  mem_we;

  logic                  div_start;
  logic                  div_done;
  logic [CEN_BITS-1:0]   div_q;
  logic [CEN_BITS-1:0]   cen;

  always_comb begin
    width_sat = frame_width;
    if (frame_width == '0) width_sat = DIM_BITS'(1);
    else if (frame_width > DIM_BITS'(MAX_COLUMNS)) width_sat = DIM_BITS'(MAX_COLUMNS);
    height_sat = frame_height;
    if (frame_height == '0) height_sat = DIM_BITS'(1);
    else if (frame_height > DIM_BITS'(MAX_ROWS)) height_sat = DIM_BITS'(MAX_ROWS);
  end

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign r_in          = s_axis_tuser ? '0 : row_counter;
  assign c_in          = s_axis_tuser ? '0 : column_counter;
  assign last_row_in   = ({1'b0, r_in} + DIM_BITS'(1)) >= height_sat;
  assign last_col_in   = ({1'b0, c_in} + DIM_BITS'(1)) >= width_sat;

  // column update, row zero starts fresh
  always_comb begin
    base = (r_cur == '0) ? '0 : rdata;
    upd  = base;
    if (bright) begin
      if (!base.run_open) begin
        upd.run_open  = 1'b1;
        upd.run_start = r_cur;
        upd.run_sum   = '0;
        upd.run_wsum  = '0;
      end
      upd.run_sum  = upd.run_sum + SUM_BITS'(pix);
      upd.run_wsum = upd.run_wsum + WSUM_BITS'(r_cur * pix);
    end
  end

  assign take = !work.best_found || (prod_run > prod_best);

  always_comb begin
    wword = work;
    if (close) begin
      wword.run_open = 1'b0;
      if (take) begin
        wword.best_found = 1'b1;
        wword.best_first = work.run_start;
        wword.best_last  = clast;
        wword.best_len   = clen;
        wword.best_sum   = work.run_sum;
        wword.best_wsum  = work.run_wsum;
      end
    end
  end

  assign mem_we    = (state == S_WR);
  assign div_start = (state == S_WR) && last_row && wword.best_found &&
                     (wword.best_sum != '0);

  llcc_col_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (c_cur),
    .wdata (wword),
    .raddr (c_cur),
    .rdata (rdata)
  );

  llcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (wword.best_wsum),
    .divisor  (wword.best_sum),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      frame_width      <= DIM_BITS'(MAX_COLUMNS);
      frame_height     <= DIM_BITS'(MAX_ROWS);
      bright_threshold <= PIXEL_BITS'(76);
      row_counter      <= '0;
      column_counter   <= '0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:     frame_width      <= cfg_wdata[DIM_BITS-1:0];
          REG_HEIGHT:    frame_height     <= cfg_wdata[DIM_BITS-1:0];
          REG_THRESHOLD: bright_threshold <= cfg_wdata;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && state != S_PUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            r_cur    <= r_in;
            c_cur    <= c_in;
            pix      <= s_axis_tdata;
            bright   <= s_axis_tdata > bright_threshold;
            last_row <= last_row_in;
            last_col <= last_col_in;
            if (last_col_in) begin
              column_counter <= '0;
              row_counter    <= last_row_in ? '0 : r_in + ROW_BITS'(1);
            end else begin
              column_counter <= c_in + COL_BITS'(1);
              row_counter    <= r_in;
            end
            state <= S_RD;
          end
        end
        S_RD: state <= S_UPD;
        S_UPD: begin
          work  <= upd;
          close <= upd.run_open && (!bright || last_row);
          clast <= bright ? r_cur : r_cur - ROW_BITS'(1);
          clen  <= bright ? LEN_BITS'({1'b0, r_cur} - {1'b0, upd.run_start} + LEN_BITS'(1))
                          : LEN_BITS'({1'b0, r_cur} - {1'b0, upd.run_start});
          state <= S_MUL;
        end
        S_MUL: begin
          prod_run  <= work.run_sum * work.best_len;
          prod_best <= work.best_sum * clen;
          state     <= S_WR;
        end
        S_WR: begin
          work <= wword;
          cen  <= '0;
          if (!last_row) state <= S_IDLE;
          else if (div_start) state <= S_DIV;
          else state <= S_PUT;
        end
        S_DIV: begin
          if (div_done) begin
            cen   <= div_q;
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'd0, cen,
                              work.best_found ? work.best_last : ROW_BITS'(0),
                              work.best_found ? work.best_first : ROW_BITS'(0),
                              work.best_found, c_cur};
            m_axis_tlast  <= last_col;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_RD)
    else $error("accepted beat did not start a column read");

  ap_div_to_put: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_done) |=> state == S_PUT)
    else $error("divider result not forwarded to output stage");

  ap_mid_row_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR && !last_row) |=> state == S_IDLE && !$rose(m_axis_tvalid))
    else $error("result produced for a pixel outside the last row");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the laser line column centroid unit: frames are
// streamed pixel by pixel under random bursts and output stalls, and each
// last-row column result is compared against a behavioral column tracker.
// ----------------------------------------------------------------------------
module tb;
  import llcc_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE      = 40;

  typedef struct {
    bit [9:0]  col;
    bit        found;
    bit [9:0]  first;
    bit [9:0]  last;
    bit [17:0] cen;
    bit        lastc;
  } spot_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_WIDTH;
  logic [15:0] cfg_wdata = '0;

  laser_line_column_centroid_unit i_dut (.*);

  always #1 clk = ~clk;

  // column tracker
  bit [10:0]       width_reg = 11'd1024;
  bit [10:0]       height_reg = 11'd1024;
  bit [15:0]       thresh_reg = 16'd76;
  int unsigned     row_pos, col_pos;
  bit              run_open [MAX_COLUMNS];
  int unsigned     run_start [MAX_COLUMNS];
  longint unsigned run_sum [MAX_COLUMNS];
  longint unsigned run_wsum [MAX_COLUMNS];
  bit              best_found [MAX_COLUMNS];
  int unsigned     best_first [MAX_COLUMNS];
  int unsigned     best_last [MAX_COLUMNS];
  int unsigned     best_len [MAX_COLUMNS];
  longint unsigned best_sum [MAX_COLUMNS];
  longint unsigned best_wsum [MAX_COLUMNS];

  spot_t pending_spots[$];
  int    errors;
  int    pixels_sent;
  int    burst_left;
  int    stall_cycles;

  function automatic int unsigned clamp_dim(bit [10:0] v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return 32'(v);
  endfunction

  function automatic void close_run(int unsigned c, int unsigned last, int unsigned len);
    bit take;
    take = !best_found[c] ||
           (run_sum[c] * longint'(best_len[c]) > best_sum[c] * longint'(len));
    if (take) begin
      best_found[c] = 1'b1;
      best_first[c] = run_start[c];
      best_last[c]  = last;
      best_len[c]   = len;
      best_sum[c]   = run_sum[c];
      best_wsum[c]  = run_wsum[c];
    end
    run_open[c] = 1'b0;
  endfunction

  function automatic void track_pixel(bit [15:0] pix, bit sof);
    int unsigned w, h, r, c;
    bit bright, last_row, last_col;
    spot_t s;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    if (sof) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    last_row = (r + 1 >= h);
    last_col = (c + 1 >= w);
    bright = pix > thresh_reg;
    if (r == 0) begin
      run_open[c] = 1'b0;
      best_found[c] = 1'b0;
      best_sum[c] = 0;
      best_wsum[c] = 0;
      best_len[c] = 0;
    end
    if (bright) begin
      if (!run_open[c]) begin
        run_open[c] = 1'b1;
        run_start[c] = r;
        run_sum[c] = 0;
        run_wsum[c] = 0;
      end
      run_sum[c] += pix;
      run_wsum[c] += longint'(r) * pix;
    end
    if (run_open[c] && (!bright || last_row)) begin
      if (bright) close_run(c, r, r - run_start[c] + 1);
      else close_run(c, r - 1, r - run_start[c]);
    end
    if (last_row) begin
      s.col   = c[9:0];
      s.found = best_found[c];
      s.first = best_found[c] ? best_first[c][9:0] : 10'd0;
      s.last  = best_found[c] ? best_last[c][9:0] : 10'd0;
      s.cen   = (best_found[c] && best_sum[c] != 0) ?
                18'(((best_wsum[c] << 8) / best_sum[c])) : 18'd0;
      s.lastc = last_col;
      pending_spots.push_back(s);
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // result checker and output stall pattern
  int unsigned out_cycle;
  always @(posedge clk) begin
    spot_t s;
    int mode;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_spots.size() == 0) begin
          report("unexpected beat, column", int'(m_axis_tdata[9:0]), 0);
        end else begin
          s = pending_spots.pop_front();
          if (m_axis_tdata[9:0] != s.col)
            report("column_index", int'(m_axis_tdata[9:0]), int'(s.col));
          if (m_axis_tdata[10] != s.found)
            report("spot_found", int'(m_axis_tdata[10]), int'(s.found));
          if (m_axis_tdata[20:11] != s.first)
            report("run_first_row", int'(m_axis_tdata[20:11]), int'(s.first));
          if (m_axis_tdata[30:21] != s.last)
            report("run_last_row", int'(m_axis_tdata[30:21]), int'(s.last));
          if (m_axis_tdata[48:31] != s.cen)
            report("centroid_row", int'(m_axis_tdata[48:31]), int'(s.cen));
          if (m_axis_tlast != s.lastc)
            report("last_column", int'(m_axis_tlast), int'(s.lastc));
        end
      end
      out_cycle++;
      mode = (out_cycle / 300) % 3;
      if (mode == 0) m_axis_tready <= 1'b1;
      else if (mode == 1) m_axis_tready <= $urandom_range(0, 1);
      else m_axis_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_pixel(bit [15:0] pix, bit sof);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= sof;
    do @(posedge clk); while (!s_axis_tready);
    track_pixel(pix, sof);
    pixels_sent++;
    burst_left--;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_spots.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, bit [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_WIDTH:     width_reg = val[10:0];
      REG_HEIGHT:    height_reg = val[10:0];
      REG_THRESHOLD: thresh_reg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [15:0] pick_pixel(bit bright);
    if (bright && thresh_reg != 16'hFFFF)
      return ($urandom_range(0, 5) == 0) ? 16'hFFFF :
             16'($urandom_range(thresh_reg + 1, 65535));
    if (!bright)
      return ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(0, thresh_reg));
    return 16'($urandom);
  endfunction

  task automatic test_single_pixel_frames();
    write_reg(REG_WIDTH, 16'd1);
    write_reg(REG_HEIGHT, 16'd1);
    send_pixel(16'd0, 1'b1);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'd77, 1'b0);
    send_pixel(16'd76, 1'b0);
    drain();
  endtask

  task automatic test_run_selection();
    write_reg(REG_WIDTH, 16'd2);
    write_reg(REG_HEIGHT, 16'd6);
    write_reg(REG_THRESHOLD, 16'd100);
    // col 0: two equal-mean runs, the earlier must win
    // col 1: dim run then brighter run reaching the last row
    send_pixel(16'd200, 1'b1); send_pixel(16'd150, 1'b0);
    send_pixel(16'd200, 1'b0); send_pixel(16'd50, 1'b0);
    send_pixel(16'd100, 1'b0); send_pixel(16'd0, 1'b0);
    send_pixel(16'd200, 1'b0); send_pixel(16'd0, 1'b0);
    send_pixel(16'd0, 1'b0);   send_pixel(16'd900, 1'b0);
    send_pixel(16'd0, 1'b0);   send_pixel(16'd1000, 1'b0);
    drain();
  endtask

  task automatic test_saturated_geometry();
    // width above range, height zero: part of one row of 1024 columns
    write_reg(REG_WIDTH, 16'h07FF);
    write_reg(REG_HEIGHT, 16'd0);
    write_reg(REG_THRESHOLD, 16'd0);
    for (int i = 0; i < 64; i++) send_pixel(16'($urandom), i == 0);
    drain();
    // width zero: one column of 48 rows
    write_reg(REG_WIDTH, 16'd0);
    write_reg(REG_HEIGHT, 16'd48);
    write_reg(REG_THRESHOLD, 16'hFFFE);
    for (int i = 0; i < 48; i++) send_pixel((i >= 43) ? 16'hFFFF : 16'd7, i == 0);
    drain();
  endtask

  task automatic test_geometry_shrink_midframe();
    write_reg(REG_WIDTH, 16'd6);
    write_reg(REG_HEIGHT, 16'd8);
    write_reg(REG_THRESHOLD, 16'd76);
    for (int i = 0; i < 23; i++) send_pixel(pick_pixel($urandom_range(0, 1)), i == 0);
    drain();
    write_reg(REG_WIDTH, 16'd3);
    write_reg(REG_HEIGHT, 16'd2);
    send_pixel(16'd500, 1'b0);
    // counters wrapped; next frame arrives without a start marker
    for (int i = 0; i < 6; i++) send_pixel(pick_pixel($urandom_range(0, 1)), 1'b0);
    drain();
  endtask

  task automatic test_random_frames();
    int w, h, n;
    bit bright;
    while (pixels_sent < 450) begin
      drain();
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 10);
      write_reg(REG_WIDTH, 16'(w));
      write_reg(REG_HEIGHT, 16'(h));
      case ($urandom_range(0, 5))
        0: write_reg(REG_THRESHOLD, 16'd0);
        1: write_reg(REG_THRESHOLD, 16'hFFFF);
        2: write_reg(REG_THRESHOLD, 16'($urandom));
        default: write_reg(REG_THRESHOLD, 16'($urandom_range(50, 3000)));
      endcase
      repeat ($urandom_range(1, 3)) begin
        n = w * h;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
        bright = 1'b0;
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) bright = !bright;
          send_pixel(($urandom_range(0, 15) == 0) ? 16'($urandom) : pick_pixel(bright),
                     (i == 0 && (row_pos != 0 || col_pos != 0 || $urandom_range(0, 3) != 0)) ||
                     $urandom_range(0, 99) == 0);
        end
        if ($urandom_range(0, 4) == 0) drain();
      end
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_pixel_frames();
    test_run_selection();
    test_geometry_shrink_midframe();
    test_saturated_geometry();
    test_random_frames();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
